/* rtl/core/rrj_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package rrj_pkg;

  typedef logic signed [31:0] s32_t;
  typedef logic signed [63:0] s64_t;

  localparam int FRAC_BITS_DEF = 16;
  localparam int QBITS = 30;
  // products of two Q2.30 terms that are doubled on the way
  localparam int QX2_SH = QBITS - 1;
  localparam int DIV_LANES = 5;
  localparam int FQ_DEPTH = 4;
  localparam int CFG_IDX_W = 3;

  localparam s32_t S32_MAX = 32'sh7FFFFFFF;
  localparam s32_t S32_MIN = 32'sh80000000;
  localparam s64_t ONE_Q30 = 64'sd1073741824;

  localparam logic [CFG_IDX_W-1:0] CFG_QX = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QZ = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_QW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PX = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PY = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PZ = 3'd6;

  typedef struct packed {
    s32_t qx;
    s32_t qy;
    s32_t qz;
    s32_t qw;
    s32_t px;
    s32_t py;
    s32_t pz;
  } pose_t;

  typedef struct packed {
    s32_t obs_u;
    s32_t obs_v;
    s32_t w00;
    s32_t w01;
    s32_t w11;
    s32_t lx;
    s32_t ly;
    s32_t lz;
  } raw_t;

  typedef struct packed {
    s32_t obs_u;
    s32_t obs_v;
    s32_t w00;
    s32_t w01;
    s32_t w11;
    s32_t [2:0] d;
  } item_t;

  typedef struct packed {
    s32_t res;
    s32_t [2:0] jq;
    s32_t jw;
    s32_t [2:0] jp;
  } row_t;

  typedef struct packed {
    row_t [1:0] row;
    logic zero;
  } res_t;

  function automatic s32_t sat32(input s64_t x);
    if (x > 64'(S32_MAX)) return S32_MAX;
    if (x < 64'(S32_MIN)) return S32_MIN;
    return x[31:0];
  endfunction

  // round to nearest, ties toward +inf
  function automatic s64_t rnd_sh(input s64_t p, input int s);
    s64_t y;
    y = p + (s64_t'(1) <<< (s - 1));
    return y >>> s;
  endfunction

  function automatic s64_t mul_rnd(input s32_t a, input s32_t b, input int s);
    s64_t p;
    p = 64'(a) * 64'(b);
    return rnd_sh(p, s);
  endfunction

endpackage
`default_nettype wire

/* rtl/core/rrj_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module rrj_front (
  input  logic           clk,
  input  logic           rst_n,
  input  rrj_pkg::pose_t pose,
  input  logic           push,
  output logic           full,
  input  rrj_pkg::raw_t  raw,
  output logic           fq_valid,
  output rrj_pkg::item_t fq_data,
  input  logic           fq_pop
);
  import rrj_pkg::*;

  localparam int PW = $clog2(FQ_DEPTH);

  raw_t            st_r;
  logic            st_v_r;
  item_t           fq_mem_r [FQ_DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [PW:0]     cnt_r;
  logic            fq_full;
  logic            accept;
  logic            move;
  item_t           it;

  assign fq_full  = (cnt_r == (PW+1)'(FQ_DEPTH));
  assign full     = st_v_r && fq_full;
  assign accept   = push && !full;
  assign move     = st_v_r && !fq_full;
  assign fq_valid = (cnt_r != '0);
  assign fq_data  = fq_mem_r[rd_ptr_r];

  always_comb begin
    it.obs_u = st_r.obs_u;
    it.obs_v = st_r.obs_v;
    it.w00   = st_r.w00;
    it.w01   = st_r.w01;
    it.w11   = st_r.w11;
    it.d[0]  = sat32(64'(st_r.lx) - 64'(pose.px));
    it.d[1]  = sat32(64'(st_r.ly) - 64'(pose.py));
    it.d[2]  = sat32(64'(st_r.lz) - 64'(pose.pz));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_v_r   <= 1'b0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (accept) begin
        st_v_r <= 1'b1;
      end else if (move) begin
        st_v_r <= 1'b0;
      end
      if (move) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (fq_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (move && !fq_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!move && fq_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_r <= raw;
    end
    if (move) begin
      fq_mem_r[wr_ptr_r] <= it;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/rrj_div.sv */
`timescale 1ns / 1ps
`default_nettype none
module rrj_div #(
  parameter int FRAC_BITS = rrj_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   en,
  input  rrj_pkg::s32_t [rrj_pkg::DIV_LANES-1:0] dvd,
  input  rrj_pkg::s32_t                          dsr,
  output rrj_pkg::s32_t [rrj_pkg::DIV_LANES-1:0] quo
);
  import rrj_pkg::*;

  localparam int N = 32 + FRAC_BITS;
  localparam int W = 32 + N;

  logic [W-1:0] acc_r   [N+1][DIV_LANES];
  logic [W-1:0] acc_nxt [N][DIV_LANES];
  logic         neg_r   [N+1][DIV_LANES];
  logic [31:0]  dsr_r   [N];
  s32_t [DIV_LANES-1:0] quo_r;

  assign quo = quo_r;

  // one quotient bit per stage, restoring
  always_comb begin
    logic [32:0] t;
    logic [32:0] df;
    for (int k = 0; k < N; k++) begin
      for (int l = 0; l < DIV_LANES; l++) begin
        t  = {acc_r[k][l][W-1:N], acc_r[k][l][N-1]};
        df = t - {1'b0, dsr_r[k]};
        if (t >= {1'b0, dsr_r[k]}) begin
          acc_nxt[k][l] = {df[31:0], acc_r[k][l][N-2:0], 1'b1};
        end else begin
          acc_nxt[k][l] = {t[31:0], acc_r[k][l][N-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [32:0]  mag;
    logic [32:0]  dmag;
    logic [N-1:0] q;
    logic         ovp;
    logic         ovn;
    if (en) begin
      dmag = dsr[31] ? -{dsr[31], dsr} : {dsr[31], dsr};
      dsr_r[0] <= dmag[31:0];
      for (int l = 0; l < DIV_LANES; l++) begin
        mag = dvd[l][31] ? -{dvd[l][31], dvd[l]} : {dvd[l][31], dvd[l]};
        acc_r[0][l] <= {32'd0, mag[31:0], {FRAC_BITS{1'b0}}};
        neg_r[0][l] <= dvd[l][31] ^ dsr[31];
      end
      for (int k = 0; k < N; k++) begin
        for (int l = 0; l < DIV_LANES; l++) begin
          acc_r[k+1][l] <= acc_nxt[k][l];
          neg_r[k+1][l] <= neg_r[k][l];
        end
      end
      for (int k = 1; k < N; k++) begin
        dsr_r[k] <= dsr_r[k-1];
      end
      for (int l = 0; l < DIV_LANES; l++) begin
        q   = acc_r[N][l][N-1:0];
        ovp = |q[N-1:31];
        ovn = (|q[N-1:32]) || (q[31] && (|q[30:0]));
        if (neg_r[N][l]) begin
          quo_r[l] <= ovn ? S32_MIN : s32_t'(-q[31:0]);
        end else begin
          quo_r[l] <= ovp ? S32_MAX : s32_t'(q[31:0]);
        end
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/rrj_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module rrj_back #(
  parameter int FRAC_BITS = rrj_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  rrj_pkg::pose_t pose,
  input  logic           fq_valid,
  input  rrj_pkg::item_t fq_data,
  output logic           fq_pop,
  output logic           res_valid,
  output rrj_pkg::res_t  res_data,
  input  logic           res_take
);
  import rrj_pkg::*;

  localparam int NDIV = 32 + FRAC_BITS;
  localparam int DL   = NDIV + 2;
  localparam int LAT  = DL + 7;

  typedef struct packed {
    item_t it;
    logic  zero;
  } side_t;

  logic [LAT-1:0] vld_r;
  logic           adv;

  // pose-derived terms, free running
  s64_t qp_r [9];
  s32_t rt_r [3][3];
  s64_t rq   [3][3];

  item_t b0_r, b1_r, b2_r;
  s64_t  zp_r [3][3];
  s32_t  z_r  [3];

  s32_t [DIV_LANES-1:0] dvd;
  s32_t [DIV_LANES-1:0] quo;
  side_t sd_r [DL];
  side_t sd;

  s32_t  e_r   [2];
  s32_t  wd_r  [3];
  s64_t  a_r   [3];
  s64_t  pv_r  [3][3];
  s64_t  rwp_r [3];
  s64_t  rwn_r [3];
  item_t t1_r;
  logic  t1z_r;
  s32_t  vq    [3];
  s64_t  pw    [3];

  s64_t  r_r [3];
  s32_t  s_r [2][3];
  s32_t  m_r [3][3];
  s32_t  c_r [3];
  logic  t2z_r;
  s64_t  vd2;
  s64_t  wsk [3][3];

  s64_t  ps_r [2][3][3];
  s64_t  pm_r [2][3][3];
  s64_t  pc_r [2][3];
  s32_t  res_r [2];
  logic  t3z_r;

  res_t  out_r;
  res_t  out_nxt;

  assign adv       = !vld_r[LAT-1] || res_take;
  assign fq_pop    = adv && fq_valid;
  assign res_valid = vld_r[LAT-1];
  assign res_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], fq_valid};
    end
  end

  // rotation: order xx yy zz xy xz yz xw yw zw
  always_ff @(posedge clk) begin
    qp_r[0] <= mul_rnd(pose.qx, pose.qx, QX2_SH);
    qp_r[1] <= mul_rnd(pose.qy, pose.qy, QX2_SH);
    qp_r[2] <= mul_rnd(pose.qz, pose.qz, QX2_SH);
    qp_r[3] <= mul_rnd(pose.qx, pose.qy, QX2_SH);
    qp_r[4] <= mul_rnd(pose.qx, pose.qz, QX2_SH);
    qp_r[5] <= mul_rnd(pose.qy, pose.qz, QX2_SH);
    qp_r[6] <= mul_rnd(pose.qx, pose.qw, QX2_SH);
    qp_r[7] <= mul_rnd(pose.qy, pose.qw, QX2_SH);
    qp_r[8] <= mul_rnd(pose.qz, pose.qw, QX2_SH);
  end

  always_comb begin
    rq[0][0] = ONE_Q30 - qp_r[1] - qp_r[2];
    rq[0][1] = qp_r[3] - qp_r[8];
    rq[0][2] = qp_r[4] + qp_r[7];
    rq[1][0] = qp_r[3] + qp_r[8];
    rq[1][1] = ONE_Q30 - qp_r[0] - qp_r[2];
    rq[1][2] = qp_r[5] - qp_r[6];
    rq[2][0] = qp_r[4] - qp_r[7];
    rq[2][1] = qp_r[5] + qp_r[6];
    rq[2][2] = ONE_Q30 - qp_r[0] - qp_r[1];
  end

  // transpose on the way in
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rt_r[i][j] <= sat32(rq[j][i]);
      end
    end
  end

  // camera-frame point
  always_ff @(posedge clk) begin
    if (adv) begin
      b0_r <= fq_data;
      b1_r <= b0_r;
      b2_r <= b1_r;
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          zp_r[i][k] <= mul_rnd(rt_r[i][k], b0_r.d[k], QBITS);
        end
        z_r[i] <= sat32(zp_r[i][0] + zp_r[i][1] + zp_r[i][2]);
      end
    end
  end

  assign dvd[0] = z_r[0];
  assign dvd[1] = z_r[1];
  assign dvd[2] = b2_r.w00;
  assign dvd[3] = b2_r.w01;
  assign dvd[4] = b2_r.w11;

  rrj_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk (clk),
    .en  (adv),
    .dvd (dvd),
    .dsr (z_r[2]),
    .quo (quo)
  );

  // carry the item alongside the divider
  always_ff @(posedge clk) begin
    if (adv) begin
      sd_r[0] <= '{it: b2_r, zero: (z_r[2] == '0)};
      for (int k = 1; k < DL; k++) begin
        sd_r[k] <= sd_r[k-1];
      end
    end
  end

  assign sd = sd_r[DL-1];

  always_comb begin
    vq[0] = pose.qx;
    vq[1] = pose.qy;
    vq[2] = pose.qz;
    for (int k = 0; k < 3; k++) begin
      pw[k] = 64'(pose.qw) * 64'(sd.it.d[k]);
    end
  end

  // error, projection terms, skew products
  always_ff @(posedge clk) begin
    if (adv) begin
      e_r[0]  <= sat32(64'(quo[0]) - 64'(sd.it.obs_u));
      e_r[1]  <= sat32(64'(quo[1]) - 64'(sd.it.obs_v));
      a_r[0]  <= mul_rnd(quo[2], quo[0], FRAC_BITS);
      a_r[1]  <= mul_rnd(quo[3], quo[1], FRAC_BITS);
      a_r[2]  <= mul_rnd(quo[4], quo[1], FRAC_BITS);
      wd_r[0] <= quo[2];
      wd_r[1] <= quo[3];
      wd_r[2] <= quo[4];
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pv_r[i][j] <= mul_rnd(vq[i], sd.it.d[j], QX2_SH);
        end
        rwp_r[i] <= rnd_sh(pw[i], QX2_SH);
        rwn_r[i] <= rnd_sh(-pw[i], QX2_SH);
      end
      t1_r  <= sd.it;
      t1z_r <= sd.zero;
    end
  end

  always_comb begin
    vd2 = pv_r[0][0] + pv_r[1][1] + pv_r[2][2];
    wsk[0][0] = '0;
    wsk[0][1] = rwn_r[2];
    wsk[0][2] = rwp_r[1];
    wsk[1][0] = rwp_r[2];
    wsk[1][1] = '0;
    wsk[1][2] = rwn_r[0];
    wsk[2][0] = rwn_r[1];
    wsk[2][1] = rwp_r[0];
    wsk[2][2] = '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r_r[0]    <= mul_rnd(t1_r.w00, e_r[0], FRAC_BITS);
      r_r[1]    <= mul_rnd(t1_r.w01, e_r[1], FRAC_BITS);
      r_r[2]    <= mul_rnd(t1_r.w11, e_r[1], FRAC_BITS);
      s_r[0][0] <= wd_r[0];
      s_r[0][1] <= wd_r[1];
      s_r[0][2] <= sat32(-(a_r[0] + a_r[1]));
      s_r[1][0] <= '0;
      s_r[1][1] <= wd_r[2];
      s_r[1][2] <= sat32(-a_r[2]);
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          m_r[i][j] <= sat32(wsk[i][j] + ((i == j) ? vd2 : s64_t'(0))
                             + pv_r[i][j] - pv_r[j][i]);
        end
      end
      c_r[0] <= sat32(rwp_r[0] - pv_r[1][2] + pv_r[2][1]);
      c_r[1] <= sat32(rwp_r[1] - pv_r[2][0] + pv_r[0][2]);
      c_r[2] <= sat32(rwp_r[2] - pv_r[0][1] + pv_r[1][0]);
      t2z_r  <= t1z_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 2; i++) begin
        for (int k = 0; k < 3; k++) begin
          for (int j = 0; j < 3; j++) begin
            ps_r[i][k][j] <= mul_rnd(s_r[i][k], rt_r[k][j], QBITS);
            pm_r[i][k][j] <= mul_rnd(s_r[i][k], m_r[k][j], FRAC_BITS);
          end
          pc_r[i][k] <= mul_rnd(s_r[i][k], c_r[k], FRAC_BITS);
        end
      end
      res_r[0] <= sat32(r_r[0] + r_r[1]);
      res_r[1] <= sat32(r_r[2]);
      t3z_r    <= t2z_r;
    end
  end

  always_comb begin
    s32_t srt;
    srt = '0;
    out_nxt = '0;
    out_nxt.zero = t3z_r;
    if (!t3z_r) begin
      for (int i = 0; i < 2; i++) begin
        out_nxt.row[i].res = res_r[i];
        for (int j = 0; j < 3; j++) begin
          out_nxt.row[i].jq[j] = sat32(pm_r[i][0][j] + pm_r[i][1][j] + pm_r[i][2][j]);
          srt = sat32(ps_r[i][0][j] + ps_r[i][1][j] + ps_r[i][2][j]);
          out_nxt.row[i].jp[j] = sat32(-64'(srt));
        end
        out_nxt.row[i].jw = sat32(pc_r[i][0] + pc_r[i][1] + pc_r[i][2]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/rrj_out.sv */
`timescale 1ns / 1ps
`default_nettype none
module rrj_out (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          res_valid,
  input  rrj_pkg::res_t res_data,
  output logic          res_take,
  output logic          empty,
  input  logic          pop,
  output rrj_pkg::row_t row,
  output logic          last_row,
  output logic          zero
);
  import rrj_pkg::*;

  logic v_r;
  logic row_r;
  res_t data_r;

  // take the next observation as its second row leaves
  assign res_take = !v_r || (pop && row_r);
  assign empty    = !v_r;
  assign row      = row_r ? data_r.row[1] : data_r.row[0];
  assign last_row = row_r;
  assign zero     = data_r.zero;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= 1'b0;
      row_r <= 1'b0;
    end else if (res_take) begin
      v_r   <= res_valid;
      row_r <= 1'b0;
    end else if (pop) begin
      row_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      data_r <= res_data;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/reprojection_residual_jacobian_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Reprojection residual and pose Jacobian, one observation in, two rows out.
// Input: drive the observation, square-root weight and landmark with push
// high; the request is taken on a clock edge where full is low.
// Output: while empty is low, the oldest row sits on the out_ ports; pop
// takes it. Row 0 comes first, then row 1 with out_last_row set.
// Configuration: write pose registers (quaternion x, y, z, w, then position
// x, y, z) through cfg_we/cfg_index/cfg_wdata between frames, while idle.
// Divide: the per-item divide by depth is a pipeline with one quotient bit
// per stage and makes up most of the path from a taken request to the
// first row of its result.
// Result port: each observation leaves as two rows on the single result
// port; the next observation can be taken as its second row is popped.
// Reset: rst_n low empties every stage and loads the identity pose.
// A stalled pop holds the pipeline in place; a short input queue keeps
// taking requests until it fills, then full rises.
// Zero depth: both rows come out with depth_zero set and zero values.
module reprojection_residual_jacobian_core #(
  parameter int FRAC_BITS = rrj_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  output logic                               full,
  input  logic signed [31:0]                 in_obs_u,
  input  logic signed [31:0]                 in_obs_v,
  input  logic signed [31:0]                 in_wsqrt_00,
  input  logic signed [31:0]                 in_wsqrt_01,
  input  logic signed [31:0]                 in_wsqrt_11,
  input  logic signed [31:0]                 in_landmark_x,
  input  logic signed [31:0]                 in_landmark_y,
  input  logic signed [31:0]                 in_landmark_z,
  output logic                               empty,
  input  logic                               pop,
  output logic                               out_last_row,
  output logic signed [31:0]                 out_residual,
  output logic signed [31:0]                 out_jac_qx,
  output logic signed [31:0]                 out_jac_qy,
  output logic signed [31:0]                 out_jac_qz,
  output logic signed [31:0]                 out_jac_qw,
  output logic signed [31:0]                 out_jac_px,
  output logic signed [31:0]                 out_jac_py,
  output logic signed [31:0]                 out_jac_pz,
  output logic                               out_depth_zero,
  input  logic                               cfg_we,
  input  logic [rrj_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                        cfg_wdata
);
  import rrj_pkg::*;

  pose_t pose_r;
  raw_t  raw;
  logic  fq_valid;
  item_t fq_data;
  logic  fq_pop;
  logic  res_valid;
  res_t  res_data;
  logic  res_take;
  row_t  row;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pose_r <= '{qx: s32_t'(0), qy: s32_t'(0), qz: s32_t'(0), qw: s32_t'(ONE_Q30),
                  px: s32_t'(0), py: s32_t'(0), pz: s32_t'(0)};
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_QX:  pose_r.qx <= cfg_wdata;
        CFG_QY:  pose_r.qy <= cfg_wdata;
        CFG_QZ:  pose_r.qz <= cfg_wdata;
        CFG_QW:  pose_r.qw <= cfg_wdata;
        CFG_PX:  pose_r.px <= cfg_wdata;
        CFG_PY:  pose_r.py <= cfg_wdata;
        CFG_PZ:  pose_r.pz <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign raw = '{obs_u: in_obs_u, obs_v: in_obs_v, w00: in_wsqrt_00,
                 w01: in_wsqrt_01, w11: in_wsqrt_11, lx: in_landmark_x,
                 ly: in_landmark_y, lz: in_landmark_z};

  rrj_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .pose     (pose_r),
    .push     (push),
    .full     (full),
    .raw      (raw),
    .fq_valid (fq_valid),
    .fq_data  (fq_data),
    .fq_pop   (fq_pop)
  );

  rrj_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pose      (pose_r),
    .fq_valid  (fq_valid),
    .fq_data   (fq_data),
    .fq_pop    (fq_pop),
    .res_valid (res_valid),
    .res_data  (res_data),
    .res_take  (res_take)
  );

  rrj_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_data  (res_data),
    .res_take  (res_take),
    .empty     (empty),
    .pop       (pop),
    .row       (row),
    .last_row  (out_last_row),
    .zero      (out_depth_zero)
  );

  assign out_residual = row.res;
  assign out_jac_qx   = row.jq[0];
  assign out_jac_qy   = row.jq[1];
  assign out_jac_qz   = row.jq[2];
  assign out_jac_qw   = row.jw;
  assign out_jac_px   = row.jp[0];
  assign out_jac_py   = row.jp[1];
  assign out_jac_pz   = row.jp[2];

endmodule
`default_nettype wire
